@@ design/aoq_pkg.sv @@
// ----------------------------------------------------------------------------
// A* open list package
// Shared widths, entry and candidate types, codes and the ordering function
// used by the cell row and the minimum-search tree.
// ----------------------------------------------------------------------------
package aoq_pkg;

   // Number of entries the list can hold.
   localparam int CAPACITY    = 64;
   // Width of one 16.8 fixed-point cost.
   localparam int COST_W      = 24;
   // Width of one cell coordinate.
   localparam int COORD_W     = 8;
   // Width of a slot index and of the held-entry count.
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   // The minimum search is a tree of 4-input nodes.
   localparam int TREE_LEVELS = ($clog2(CAPACITY) + 1) / 2;
   localparam int LEAVES      = 4 ** TREE_LEVELS;
   localparam int LVL_CNT_W   = (TREE_LEVELS > 1) ? $clog2(TREE_LEVELS) : 1;

   // Request kinds.
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_PEEK   = 2'd1;
   localparam logic [1:0] KIND_POP    = 2'd2;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_NEW      = 3'd0,
      ST_REPLACED = 3'd1,
      ST_REJECTED = 3'd2,
      ST_FULL     = 3'd3,
      ST_GIVEN    = 3'd4,
      ST_EMPTY    = 3'd5
   } status_type;

   // One list entry.
   typedef struct packed {
      logic [COST_W-1:0]  total;
      logic [COST_W-1:0]  path;
      logic [COST_W-1:0]  heur;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] layer;
   } entry_type;

   // Update command for one cell of the row.
   typedef struct packed {
      logic take_left;
      logic take_right;
   } cell_cmd_type;

   // Candidate travelling through the minimum-search tree.
   typedef struct packed {
      logic             valid;
      entry_type        entry;
      logic [IDX_W-1:0] idx;
   } cand_type;

   // True if candidate x orders strictly before candidate y.
   function automatic logic cand_before(cand_type x, cand_type y, logic tie_larger);
      logic result;
      begin
         if (!x.valid) begin
            result = 1'b0;
         end else if (!y.valid) begin
            result = 1'b1;
         end else if (x.entry.total != y.entry.total) begin
            result = (x.entry.total < y.entry.total);
         end else if (x.entry.path != y.entry.path) begin
            result = tie_larger ? (x.entry.path > y.entry.path)
                                : (x.entry.path < y.entry.path);
         end else begin
            result = (x.entry.row < y.entry.row);
         end
         return result;
      end
   endfunction

endpackage

@@ design/astar_open_list_priority_queue_core.sv @@
// ----------------------------------------------------------------------------
// A* open list priority queue core
// Open list for grid path search with decrease-key, built as a row of cells
// and a registered minimum-search tree.
// ----------------------------------------------------------------------------
// Usage:
//   Requests are taken when start is high and busy is low. Kind insert adds
//   or replaces an entry, peek reports the minimum, pop reports and removes
//   it. Each request yields one result beat on the rsp_ ports, marked by
//   rsp_strobe for exactly one cycle; the receiver cannot stall it.
//   Sequence: an insert is accepted, searches the cell row for the same cell
//   in the next cycle and shows its result in the cycle after; busy is high
//   only while it searches. Peek and pop run through the minimum tree of
//   TREE_LEVELS 4-input levels (3 for 64 entries), with a register after
//   every level but the last; busy stays high while the tree is walked. Peek
//   or pop on an empty list answers with status empty without raising busy.
//   The tree depth sets the peek and pop rate; the row compare sets insert.
//   The csr_ port writes the tie rule; write it only while busy is low.
//   Reset empties the list and sets the tie rule to prefer the larger path
//   cost.
// ----------------------------------------------------------------------------
module astar_open_list_priority_queue_core (
   input  logic                         clock,
   input  logic                         reset,
   // Request channel
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_kind,
   input  logic [23:0]                  req_total_cost,
   input  logic [23:0]                  req_path_cost,
   input  logic [23:0]                  req_heuristic_cost,
   input  logic [7:0]                   req_cell_row,
   input  logic [7:0]                   req_cell_col,
   input  logic [7:0]                   req_cell_layer,
   // Result channel
   output logic                         rsp_strobe,
   output logic [2:0]                   rsp_status,
   output logic [23:0]                  rsp_out_total_cost,
   output logic [23:0]                  rsp_out_path_cost,
   output logic [23:0]                  rsp_out_heuristic_cost,
   output logic [7:0]                   rsp_out_row,
   output logic [7:0]                   rsp_out_col,
   output logic [7:0]                   rsp_out_layer,
   output logic [6:0]                   rsp_entry_count,
   // Configuration
   input  logic                         csr_wr_en,
   input  logic                         csr_wr_data
);
   import aoq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FIND,
      S_TREE
   } state_type;

   state_type            state_ff;
   logic [1:0]           kind_ff;
   entry_type            req_ff;
   logic [CNT_W-1:0]     held_ff;
   logic [LVL_CNT_W-1:0] lvl_ff;
   logic                 tie_ff;
   logic                 rsp_strobe_ff;
   status_type           rsp_status_ff;
   entry_type            rsp_entry_ff;
   logic [CNT_W-1:0]     rsp_count_ff;

   entry_type            req_in;
   entry_type            cell_entry [CAPACITY];
   logic [CAPACITY-1:0]  cell_valid;
   logic [CAPACITY-1:0]  cell_match;
   logic [CAPACITY-1:0]  cell_lower;
   cell_cmd_type         cell_cmd [CAPACITY];

   logic                 found;
   logic                 better;
   logic [IDX_W-1:0]     match_idx;
   logic                 full;
   logic                 do_shift;
   logic [CNT_W-1:0]     shift_limit;
   status_type           ins_status;
   logic                 tree_done;
   logic                 do_remove;

   cand_type             leaf [LEAVES];
   cand_type             node_in [TREE_LEVELS][LEAVES/4];
   cand_type             node_ff [TREE_LEVELS-1][LEAVES/4];
   cand_type             best;

   assign req_in = '{total: req_total_cost, path: req_path_cost, heur: req_heuristic_cost,
                     row: req_cell_row, col: req_cell_col, layer: req_cell_layer};

   // Row of cells: slot 0 holds the newest entry, valid slots are compacted.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type left_entry;
      logic      left_valid;
      entry_type right_entry;
      logic      right_valid;

      if (i == 0) begin : g_head
         assign left_entry = req_ff;
         assign left_valid = 1'b1;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_valid = cell_valid[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry = req_ff;
         assign right_valid = 1'b0;
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
         assign right_valid = cell_valid[i+1];
      end

      // Insert shifts slots up to the matched slot or the first free one.
      assign cell_cmd[i].take_left  = (state_ff == S_FIND) && do_shift
                                      && (CNT_W'(i) <= shift_limit);
      // Pop closes the gap left by the removed minimum.
      assign cell_cmd[i].take_right = do_remove && (IDX_W'(i) >= best.idx);

      aoq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cell_cmd[i]),
         .key         (req_ff),
         .left_entry  (left_entry),
         .left_valid  (left_valid),
         .right_entry (right_entry),
         .right_valid (right_valid),
         .entry       (cell_entry[i]),
         .valid       (cell_valid[i]),
         .match       (cell_match[i]),
         .key_lower   (cell_lower[i])
      );
   end

   // Insert decision: a held cell is unique, so at most one bit of the match vector is set.
   always_comb begin
      match_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (cell_match[i]) begin
            match_idx = match_idx | IDX_W'(i);
         end
      end
      found       = |cell_match;
      better      = |(cell_match & cell_lower);
      full        = (held_ff == CNT_W'(CAPACITY));
      do_shift    = found ? better : !full;
      shift_limit = found ? {1'b0, match_idx} : held_ff;
      if (found) begin
         ins_status = better ? ST_REPLACED : ST_REJECTED;
      end else begin
         ins_status = full ? ST_FULL : ST_NEW;
      end
   end

   // Tree leaves, padded with empty candidates.
   for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
      if (i < CAPACITY) begin : g_used
         assign leaf[i] = '{valid: cell_valid[i], entry: cell_entry[i], idx: IDX_W'(i)};
      end else begin : g_pad
         assign leaf[i] = '0;
      end
   end

   // Minimum-search tree with a register after every level but the last.
   for (genvar l = 0; l < TREE_LEVELS; l++) begin : g_level
      for (genvar n = 0; n < 4 ** (TREE_LEVELS - 1 - l); n++) begin : g_node
         cand_type node_cand [4];

         for (genvar j = 0; j < 4; j++) begin : g_src
            if (l == 0) begin : g_from_leaf
               assign node_cand[j] = leaf[4*n + j];
            end else begin : g_from_reg
               assign node_cand[j] = node_ff[l-1][4*n + j];
            end
         end

         aoq_pick4 u_pick (
            .tie_larger (tie_ff),
            .cand       (node_cand),
            .best       (node_in[l][n])
         );

         if (l < TREE_LEVELS - 1) begin : g_reg
            always_ff @(posedge clock) begin
               node_ff[l][n] <= node_in[l][n];
            end
         end
      end
   end

   assign best      = node_in[TREE_LEVELS-1][0];
   assign tree_done = (lvl_ff == LVL_CNT_W'(TREE_LEVELS - 1));
   assign do_remove = (state_ff == S_TREE) && tree_done && (kind_ff == KIND_POP);

   // Control sequence, entry count and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         held_ff       <= '0;
         lvl_ff        <= '0;
         tie_ff        <= 1'b1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (csr_wr_en) begin
            tie_ff <= csr_wr_data;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  kind_ff <= req_kind;
                  req_ff  <= req_in;
                  lvl_ff  <= '0;
                  if (req_kind == KIND_INSERT) begin
                     state_ff <= S_FIND;
                  end else if (held_ff == '0) begin
                     rsp_strobe_ff <= 1'b1;
                     rsp_status_ff <= ST_EMPTY;
                     rsp_entry_ff  <= '0;
                     rsp_count_ff  <= held_ff;
                  end else begin
                     state_ff <= S_TREE;
                  end
               end
            end
            S_FIND: begin
               rsp_strobe_ff <= 1'b1;
               rsp_status_ff <= ins_status;
               rsp_entry_ff  <= '0;
               if (!found && !full) begin
                  held_ff      <= held_ff + CNT_W'(1);
                  rsp_count_ff <= held_ff + CNT_W'(1);
               end else begin
                  rsp_count_ff <= held_ff;
               end
               state_ff <= S_IDLE;
            end
            S_TREE: begin
               if (!tree_done) begin
                  lvl_ff <= lvl_ff + LVL_CNT_W'(1);
               end else begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_status_ff <= ST_GIVEN;
                  rsp_entry_ff  <= best.entry;
                  if (kind_ff == KIND_POP) begin
                     held_ff      <= held_ff - CNT_W'(1);
                     rsp_count_ff <= held_ff - CNT_W'(1);
                  end else begin
                     rsp_count_ff <= held_ff;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy                   = (state_ff != S_IDLE);
   assign rsp_strobe             = rsp_strobe_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_out_total_cost     = rsp_entry_ff.total;
   assign rsp_out_path_cost      = rsp_entry_ff.path;
   assign rsp_out_heuristic_cost = rsp_entry_ff.heur;
   assign rsp_out_row            = rsp_entry_ff.row;
   assign rsp_out_col            = rsp_entry_ff.col;
   assign rsp_out_layer          = rsp_entry_ff.layer;
   assign rsp_entry_count        = 7'(rsp_count_ff);

`ifndef ASSERT_OFF
   // The count never exceeds the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CNT_W'(CAPACITY))
      else $error("held entry count above capacity");

   // The count matches the valid cells.
   a_count_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(held_ff))
      else $error("held entry count differs from valid cells");

   // Valid cells stay packed toward slot 0.
   a_compact: assert property (@(posedge clock) disable iff (reset)
      ((cell_valid >> 1) & ~cell_valid) == '0)
      else $error("gap in the cell row");

   // A cell is held at most once.
   a_unique: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIND) |-> $onehot0(cell_match))
      else $error("cell held in more than one slot");

   // A result beat follows only a request in progress.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff != S_IDLE || start))
      else $error("result beat without a request");
`endif

endmodule

@@ design/aoq_cell.sv @@
// ----------------------------------------------------------------------------
// A* open list cell
// One slot of the compacted entry row. It compares its entry against the
// search key and takes its neighbor's entry when the row shifts.
// ----------------------------------------------------------------------------
module aoq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  aoq_pkg::cell_cmd_type cmd,
   input  aoq_pkg::entry_type    key,
   input  aoq_pkg::entry_type    left_entry,
   input  logic                  left_valid,
   input  aoq_pkg::entry_type    right_entry,
   input  logic                  right_valid,
   output aoq_pkg::entry_type    entry,
   output logic                  valid,
   output logic                  match,
   output logic                  key_lower
);
   import aoq_pkg::*;

   entry_type entry_ff;
   logic      valid_ff;

   // Shift toward the tail on insert, toward the head on removal.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.take_left) begin
         valid_ff <= left_valid;
      end else if (cmd.take_right) begin
         valid_ff <= right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_left) begin
         entry_ff <= left_entry;
      end else if (cmd.take_right) begin
         entry_ff <= right_entry;
      end
   end

   // Same-cell detection and the decrease-key cost test.
   assign match     = valid_ff && (entry_ff.row == key.row) && (entry_ff.col == key.col)
                      && (entry_ff.layer == key.layer);
   assign key_lower = (key.total < entry_ff.total);
   assign entry     = entry_ff;
   assign valid     = valid_ff;

endmodule

@@ design/aoq_pick4.sv @@
// ----------------------------------------------------------------------------
// A* open list minimum node
// Selects the best of four candidates; on a full tie the candidate with the
// lower slot index, which is the newer entry, wins.
// ----------------------------------------------------------------------------
module aoq_pick4 (
   input  logic              tie_larger,
   input  aoq_pkg::cand_type cand [4],
   output aoq_pkg::cand_type best
);
   import aoq_pkg::*;

   cand_type low_pair;
   cand_type high_pair;

   // Two pairwise compares, then one between the pair winners.
   always_comb begin
      low_pair  = cand_before(cand[1], cand[0], tie_larger) ? cand[1] : cand[0];
      high_pair = cand_before(cand[3], cand[2], tie_larger) ? cand[3] : cand[2];
      best      = cand_before(high_pair, low_pair, tie_larger) ? high_pair : low_pair;
   end

endmodule
